// ----- design/rpnp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpnp_pkg: shared types and constants for the ray pick block
// Field widths, accumulator sizing, multiply sequencer steps and register map.
// ----------------------------------------------------------------------------
package rpnp_pkg;

    localparam int COORD_W  = 24;              // coordinate field width
    localparam int DIFF_W   = COORD_W + 1;     // difference of two coordinates
    localparam int MUL_W    = DIFF_W + 2;      // multiplier operand, signed
    localparam int PROD_W   = 2 * MUL_W;       // full multiplier product
    localparam int ACC_W    = 53;              // holds every running sum exactly
    localparam int DIST_W   = 51;              // squared lengths
    localparam int CROSS_W  = 50;              // cross product component
    localparam int KMAG_W   = 26;              // magnitude of a small cross component
    localparam int CSQ_W    = 52;              // sum of cross component squares
    localparam int SCALE_W  = CSQ_W + 9;       // 400 times that sum
    localparam int INDEX_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_POINTS = 65536;
    localparam logic [INDEX_W-1:0] COUNT_CAP =
        ((MAX_POINTS - 1) > 65535) ? 16'hFFFF : INDEX_W'(MAX_POINTS - 1);

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_Z  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // one multiply per step; the flush step only drains the last product
    typedef enum logic [3:0] {
        MS_BXBX, MS_BYBY, MS_BZBZ,
        MS_CXCX, MS_CYCY, MS_CZCZ,
        MS_BYCZ, MS_BZCY,
        MS_BZCX, MS_BXCZ,
        MS_BXCY, MS_BYCX,
        MS_K0K0, MS_K1K1, MS_K2K2,
        MS_FLUSH
    } t_step;

endpackage

// ----- design/ray_pick_nearest_point.sv -----
// ----------------------------------------------------------------------------
// ray_pick_nearest_point: nearest cloud point along a view ray
// Tests each streamed point against the ray and keeps the closest candidate.
// ----------------------------------------------------------------------------
// The ray runs from the near point to the far point, both written through the
// configuration port (index 0..5: near x/y/z, far x/y/z), by the user only
// while the block idles; the block itself does not enforce this. Cloud points
// enter on the input channel (i_in_valid / o_in_stall), the last point of a
// query flagged by i_last_point. One item is taken when valid is high and
// stall is low. Each point passes through a capture, the fifteen multiplies of
// |AB|^2, |AC|^2, the cross product and its squared length plus a flush step,
// all through one shared 27x27 multiplier and accumulator, then the tolerance
// test and the best-point update. o_in_stall is high while a point is in work.
// A last point then goes to a state that loads the result into an output
// register, where o_out_valid (with i_out_stall) rises; if a previous result
// is still stalled there, the block waits and keeps o_in_stall high until it
// is taken, and only then takes the next point.
// Reset clears the configuration registers, the state machine, the query
// state and the output valid.
// ----------------------------------------------------------------------------
module ray_pick_nearest_point (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpnp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpnp_pkg::COORD_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [rpnp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpnp_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [rpnp_pkg::COORD_W-1:0] i_point_z,
    input  logic                              i_last_point,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic signed [rpnp_pkg::COORD_W-1:0] o_pick_x,
    output logic signed [rpnp_pkg::COORD_W-1:0] o_pick_y,
    output logic signed [rpnp_pkg::COORD_W-1:0] o_pick_z,
    output logic [rpnp_pkg::INDEX_W-1:0]      o_pick_index
);
    import rpnp_pkg::*;

    t_state r_state, n_state;
    t_step  r_step;

    logic signed [COORD_W-1:0] r_near_x, r_near_y, r_near_z;
    logic signed [COORD_W-1:0] r_far_x, r_far_y, r_far_z;

    // captured point and differences
    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic                      r_last;
    logic signed [DIFF_W-1:0]  r_bx, r_by, r_bz, r_cx, r_cy, r_cz;

    // shared multiplier and accumulator
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_full;
    logic signed [ACC_W-1:0]  r_prod, r_acc, acc_in, acc_next;
    logic                     prev_first, prev_sub;
    t_step                    prev_step;

    logic [DIST_W-1:0] r_ab2, r_ac2;
    logic [KMAG_W-1:0] r_k0m, r_k1m, r_k2m;
    logic              r_k0ok, r_k1ok, r_k2ok;
    logic [CSQ_W-1:0]  r_cross2;
    logic [CROSS_W-1:0] kmag;
    logic               k_ok;
    logic               r_cand;
    logic [SCALE_W-1:0] scaled;

    // query state
    logic               r_have;
    logic [DIST_W-1:0]  r_best_d;
    logic signed [COORD_W-1:0] r_best_x, r_best_y, r_best_z;
    logic [INDEX_W-1:0] r_best_idx, r_count;
    logic [DIST_W-1:0]  eff_best;
    logic               closer;

    logic               r_out_valid, r_found;
    logic signed [COORD_W-1:0] r_pick_x, r_pick_y, r_pick_z;
    logic [INDEX_W-1:0] r_pick_idx;
    logic               out_free, in_take;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_pick_x    = r_pick_x;
    assign o_pick_y    = r_pick_y;
    assign o_pick_z    = r_pick_z;
    assign o_pick_index = r_pick_idx;

    // operand select for the step being issued
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            MS_BXBX: begin mul_a = MUL_W'(r_bx); mul_b = MUL_W'(r_bx); end
            MS_BYBY: begin mul_a = MUL_W'(r_by); mul_b = MUL_W'(r_by); end
            MS_BZBZ: begin mul_a = MUL_W'(r_bz); mul_b = MUL_W'(r_bz); end
            MS_CXCX: begin mul_a = MUL_W'(r_cx); mul_b = MUL_W'(r_cx); end
            MS_CYCY: begin mul_a = MUL_W'(r_cy); mul_b = MUL_W'(r_cy); end
            MS_CZCZ: begin mul_a = MUL_W'(r_cz); mul_b = MUL_W'(r_cz); end
            MS_BYCZ: begin mul_a = MUL_W'(r_by); mul_b = MUL_W'(r_cz); end
            MS_BZCY: begin mul_a = MUL_W'(r_bz); mul_b = MUL_W'(r_cy); end
            MS_BZCX: begin mul_a = MUL_W'(r_bz); mul_b = MUL_W'(r_cx); end
            MS_BXCZ: begin mul_a = MUL_W'(r_bx); mul_b = MUL_W'(r_cz); end
            MS_BXCY: begin mul_a = MUL_W'(r_bx); mul_b = MUL_W'(r_cy); end
            MS_BYCX: begin mul_a = MUL_W'(r_by); mul_b = MUL_W'(r_cx); end
            MS_K0K0: begin
                mul_a = $signed({1'b0, r_k0m});
                mul_b = $signed({1'b0, r_k0m});
            end
            MS_K1K1: begin
                mul_a = $signed({1'b0, r_k1m});
                mul_b = $signed({1'b0, r_k1m});
            end
            MS_K2K2: begin
                mul_a = $signed({1'b0, r_k2m});
                mul_b = $signed({1'b0, r_k2m});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_full  = mul_a * mul_b;
    assign prev_step = t_step'(r_step - 4'd1);

    // accumulate the registered product of the previous step
    always_comb begin
        prev_first = (prev_step == MS_BXBX) || (prev_step == MS_CXCX) ||
                     (prev_step == MS_BYCZ) || (prev_step == MS_BZCX) ||
                     (prev_step == MS_BXCY) || (prev_step == MS_K0K0);
        prev_sub   = (prev_step == MS_BZCY) || (prev_step == MS_BXCZ) ||
                     (prev_step == MS_BYCX);
        acc_in     = prev_first ? '0 : r_acc;
        acc_next   = prev_sub ? (acc_in - r_prod) : (acc_in + r_prod);
        kmag       = acc_next[CROSS_W-1] ? (~acc_next[CROSS_W-1:0] + 1'b1)
                                         : acc_next[CROSS_W-1:0];
        // magnitude at most 2^25
        k_ok       = (kmag[CROSS_W-1:KMAG_W] == '0) &&
                     !(kmag[KMAG_W-1] && (kmag[KMAG_W-2:0] != '0));
    end

    // 400 * cross2 as shifts and adds
    assign scaled = (SCALE_W'(r_cross2) << 8) + (SCALE_W'(r_cross2) << 7) +
                    (SCALE_W'(r_cross2) << 4);

    assign eff_best = r_have ? r_best_d : r_ab2;
    assign closer   = r_ac2 < eff_best;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_take) begin n_state = ST_MUL; end
            ST_MUL:    if (r_step == MS_FLUSH) begin n_state = ST_TEST; end
            ST_TEST:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (out_free) begin n_state = ST_IDLE; end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_x <= '0;
            r_near_y <= '0;
            r_near_z <= '0;
            r_far_x  <= '0;
            r_far_y  <= '0;
            r_far_z  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR_X: r_near_x <= i_cfg_data;
                CFG_NEAR_Y: r_near_y <= i_cfg_data;
                CFG_NEAR_Z: r_near_z <= i_cfg_data;
                CFG_FAR_X:  r_far_x  <= i_cfg_data;
                CFG_FAR_Y:  r_far_y  <= i_cfg_data;
                CFG_FAR_Z:  r_far_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture and sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= MS_BXBX;
        end else begin
            if (in_take) begin
                r_step <= MS_BXBX;
            end else if (r_state == ST_MUL && r_step != MS_FLUSH) begin
                r_step <= t_step'(r_step + 4'd1);
            end
        end

        if (in_take) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
            r_last <= i_last_point;
            r_bx <= $signed({r_far_x[COORD_W-1], r_far_x}) -
                    $signed({r_near_x[COORD_W-1], r_near_x});
            r_by <= $signed({r_far_y[COORD_W-1], r_far_y}) -
                    $signed({r_near_y[COORD_W-1], r_near_y});
            r_bz <= $signed({r_far_z[COORD_W-1], r_far_z}) -
                    $signed({r_near_z[COORD_W-1], r_near_z});
            r_cx <= $signed({i_point_x[COORD_W-1], i_point_x}) -
                    $signed({r_near_x[COORD_W-1], r_near_x});
            r_cy <= $signed({i_point_y[COORD_W-1], i_point_y}) -
                    $signed({r_near_y[COORD_W-1], r_near_y});
            r_cz <= $signed({i_point_z[COORD_W-1], i_point_z}) -
                    $signed({r_near_z[COORD_W-1], r_near_z});
        end

        if (r_state == ST_MUL) begin
            r_prod <= mul_full[ACC_W-1:0];
            if (r_step != MS_BXBX) begin
                r_acc <= acc_next;
                unique case (prev_step)
                    MS_BZBZ: r_ab2 <= acc_next[DIST_W-1:0];
                    MS_CZCZ: r_ac2 <= acc_next[DIST_W-1:0];
                    MS_BZCY: begin r_k0m <= kmag[KMAG_W-1:0]; r_k0ok <= k_ok; end
                    MS_BXCZ: begin r_k1m <= kmag[KMAG_W-1:0]; r_k1ok <= k_ok; end
                    MS_BYCX: begin r_k2m <= kmag[KMAG_W-1:0]; r_k2ok <= k_ok; end
                    MS_K2K2: r_cross2 <= acc_next[CSQ_W-1:0];
                    default: ;
                endcase
            end
        end

        if (r_state == ST_TEST) begin
            r_cand <= r_k0ok && r_k1ok && r_k2ok &&
                      (scaled < SCALE_W'(r_ab2));
        end
    end

    // query state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_d    <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_z    <= '0;
            r_best_idx  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_UPDATE) begin
                if (r_cand) begin
                    r_have <= 1'b1;
                    if (closer) begin
                        r_best_d <= r_ac2;
                    end else if (!r_have) begin
                        r_best_d <= r_ab2;
                    end
                    // first candidate is always taken
                    if (closer || !r_have) begin
                        r_best_x   <= r_px;
                        r_best_y   <= r_py;
                        r_best_z   <= r_pz;
                        r_best_idx <= r_count;
                    end
                end
                if (r_count < COUNT_CAP) begin
                    r_count <= r_count + 1'b1;
                end
            end

            if (r_state == ST_EMIT && out_free) begin
                r_have      <= 1'b0;
                r_best_d    <= '0;
                r_best_x    <= '0;
                r_best_y    <= '0;
                r_best_z    <= '0;
                r_best_idx  <= '0;
                r_count     <= '0;
            end
        end

        if (r_state == ST_EMIT && out_free) begin
            r_found    <= r_have;
            r_pick_x   <= r_have ? r_best_x : '0;
            r_pick_y   <= r_have ? r_best_y : '0;
            r_pick_z   <= r_have ? r_best_z : '0;
            r_pick_idx <= r_have ? r_best_idx : '0;
        end
    end

endmodule
